// ----- rtl/shuffled_minimal_standard_prng_top_macros.svh -----
// Assertion helpers for the checks in the top-level design file.
`ifndef SHUFFLED_MINIMAL_STANDARD_PRNG_TOP_MACROS_SVH
`define SHUFFLED_MINIMAL_STANDARD_PRNG_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SMSP_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SMSP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/smsp_pkg.sv -----
package smsp_pkg;

    localparam int unsigned VALUE_W       = 31;
    localparam int unsigned MULT_W        = 15;
    localparam int unsigned TABLE_ENTRIES = 32;
    localparam int unsigned WARMUP_STEPS  = 8;
    localparam int unsigned FILL_STEPS    = TABLE_ENTRIES + WARMUP_STEPS;
    localparam int unsigned TBL_IDX_W     = $clog2(TABLE_ENTRIES);
    localparam int unsigned FILL_CNT_W    = $clog2(FILL_STEPS);
    localparam int unsigned CMD_DEPTH     = 2;
    localparam int unsigned CMD_PTR_W     = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
    localparam int unsigned CMD_CNT_W     = $clog2(CMD_DEPTH + 1);

    localparam logic [MULT_W-1:0]  LCG_MULT = 15'd16807;
    localparam logic [VALUE_W-1:0] LCG_MOD  = 31'h7FFF_FFFF;
    localparam logic [VALUE_W-1:0] SEED_ONE = 31'd1;

    // Table selection divides by a power of two, so it is a plain shift.
    localparam int unsigned SEL_DIV   = 1 + 2147483646 / TABLE_ENTRIES;
    localparam int unsigned SEL_SHIFT = $clog2(SEL_DIV);

    typedef struct packed {
        logic do_seed;
    } cmd_t;

    typedef struct packed {
        logic filling;
    } bk_status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_FILL,
        BK_DRAW
    } bk_state_t;

    // One Lehmer step. The modulus is 2^31-1, so the high part of the
    // product folds back onto the low part and one subtract finishes it.
    function automatic logic [VALUE_W-1:0] lehmer_step(input logic [VALUE_W-1:0] x);
        logic [VALUE_W+MULT_W-1:0] prod;
        logic [VALUE_W:0]          fold;
        prod = {{MULT_W{1'b0}}, x} * {{VALUE_W{1'b0}}, LCG_MULT};
        fold = {1'b0, prod[VALUE_W-1:0]}
             + {{(VALUE_W+1-MULT_W){1'b0}}, prod[VALUE_W+MULT_W-1:VALUE_W]};
        if (fold >= {1'b0, LCG_MOD}) begin
            fold = fold - {1'b0, LCG_MOD};
        end
        return fold[VALUE_W-1:0];
    endfunction

endpackage

// ----- rtl/smsp_front.sv -----
module smsp_front
    import smsp_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  logic s_reseed,
    output logic push_valid,
    input  logic push_ready,
    output cmd_t push_cmd
);

    logic seeded_reg;
    logic seeded_next;

    assign s_ready    = push_ready;
    assign push_valid = s_valid;

    // The first word after reset always seeds, so the back end never reads
    // an unwritten table entry.
    always_comb begin
        push_cmd.do_seed = s_reseed | ~seeded_reg;
        seeded_next      = seeded_reg | (s_valid & push_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seeded_reg <= 1'b0;
        end else begin
            seeded_reg <= seeded_next;
        end
    end

endmodule

// ----- rtl/smsp_cmd_fifo.sv -----
module smsp_cmd_fifo
    import smsp_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_cmd,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_cmd
);

    cmd_t                 entry_reg [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] wr_ptr_reg;
    logic [CMD_PTR_W-1:0] wr_ptr_next;
    logic [CMD_PTR_W-1:0] rd_ptr_reg;
    logic [CMD_PTR_W-1:0] rd_ptr_next;
    logic [CMD_CNT_W-1:0] count_reg;
    logic [CMD_CNT_W-1:0] count_next;
    logic                 do_push;
    logic                 do_pop;

    assign push_ready = (count_reg != CMD_CNT_W'(CMD_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid & push_ready;
    assign do_pop     = pop_valid & pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- rtl/smsp_back.sv -----
module smsp_back
    import smsp_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [VALUE_W-1:0] seed,
    input  logic               cmd_valid,
    output logic               cmd_pop,
    input  cmd_t               cmd,
    output bk_status_t         status,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [VALUE_W-1:0] m_random_value
);

    bk_state_t               state_reg;
    bk_state_t               state_next;
    logic [FILL_CNT_W-1:0]   cnt_reg;
    logic [FILL_CNT_W-1:0]   cnt_next;
    logic [VALUE_W-1:0]      lehmer_reg;
    logic [VALUE_W-1:0]      last_reg;
    logic [VALUE_W-1:0]      tbl_reg [TABLE_ENTRIES];
    logic                    m_valid_reg;
    logic                    m_valid_next;
    logic [VALUE_W-1:0]      m_data_reg;

    logic                    out_free;
    logic                    seed_load;
    logic                    fill_step;
    logic                    draw;
    logic [VALUE_W-1:0]      step_val;
    logic [VALUE_W-1:0]      seed_fixed;
    logic [VALUE_W-1:0]      sel_wide;
    logic [TBL_IDX_W-1:0]    sel;
    logic [VALUE_W-1:0]      draw_val;
    logic                    tbl_we;
    logic [TBL_IDX_W-1:0]    tbl_waddr;

    assign out_free       = ~m_valid_reg | m_ready;
    assign m_valid        = m_valid_reg;
    assign m_random_value = m_data_reg;
    assign status.filling = (state_reg == BK_FILL);

    assign step_val   = lehmer_step(lehmer_reg);
    assign seed_fixed = ((seed == '0) || (seed == LCG_MOD)) ? SEED_ONE : seed;

    always_comb begin
        sel_wide = last_reg >> SEL_SHIFT;
        if (sel_wide >= VALUE_W'(TABLE_ENTRIES)) begin
            sel = TBL_IDX_W'(TABLE_ENTRIES - 1);
        end else begin
            sel = sel_wide[TBL_IDX_W-1:0];
        end
    end

    assign draw_val = tbl_reg[sel];

    // Control outputs of the sequencer.
    always_comb begin
        cmd_pop   = 1'b0;
        seed_load = 1'b0;
        fill_step = 1'b0;
        draw      = 1'b0;
        case (state_reg)
            BK_IDLE: begin
                if (cmd_valid) begin
                    if (cmd.do_seed) begin
                        cmd_pop   = 1'b1;
                        seed_load = 1'b1;
                    end else if (out_free) begin
                        cmd_pop = 1'b1;
                        draw    = 1'b1;
                    end
                end
            end
            BK_FILL: begin
                fill_step = 1'b1;
            end
            BK_DRAW: begin
                draw = out_free;
            end
            default: begin
            end
        endcase
    end

    // Next state of the sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: begin
                if (seed_load) begin
                    state_next = BK_FILL;
                end
            end
            BK_FILL: begin
                if (cnt_reg == '0) begin
                    state_next = BK_DRAW;
                end
            end
            BK_DRAW: begin
                if (draw) begin
                    state_next = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb begin
        cnt_next = cnt_reg;
        if (seed_load) begin
            cnt_next = FILL_CNT_W'(FILL_STEPS - 1);
        end else if (fill_step && cnt_reg != '0) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    // The fill writes the table from the top entry down; the warm-up steps
    // above the table are discarded.
    always_comb begin
        tbl_we    = 1'b0;
        tbl_waddr = sel;
        if (fill_step) begin
            tbl_we    = (cnt_reg < FILL_CNT_W'(TABLE_ENTRIES));
            tbl_waddr = cnt_reg[TBL_IDX_W-1:0];
        end else if (draw) begin
            tbl_we = 1'b1;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (draw) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (seed_load) begin
            lehmer_reg <= seed_fixed;
        end else if (fill_step || draw) begin
            lehmer_reg <= step_val;
        end
        if (fill_step && cnt_reg == '0) begin
            last_reg <= step_val;
        end else if (draw) begin
            last_reg <= draw_val;
        end
        if (draw) begin
            m_data_reg <= draw_val;
        end
        if (tbl_we) begin
            tbl_reg[tbl_waddr] <= step_val;
        end
    end

endmodule

// ----- rtl/shuffled_minimal_standard_prng_top.sv -----
// Channel   Direction  Handshake          Word
// s_        in         s_valid/s_ready    s_reseed
// m_        out        m_valid/m_ready    m_random_value
// cfg_      in         cfg_wr_en          cfg_seed_value
//
// A plain draw runs in the back-end sequencer's idle state; draws stream at one per cycle while m_ready allows.
// A seeding draw (first after reset, or reseed set) first loads the seed, then runs
// 40 Lehmer steps that discard eight values and fill the 32-entry shuffle table.
// Reset is synchronous and active low; the seed register resets to one.
// A two-word command queue lets requests arrive while the sequencer fills or m_ready is low.
`include "shuffled_minimal_standard_prng_top_macros.svh"

module shuffled_minimal_standard_prng_top
    import smsp_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [VALUE_W-1:0] cfg_seed_value,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_reseed,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [VALUE_W-1:0] m_random_value
);

    logic [VALUE_W-1:0] seed_reg;
    logic               push_valid;
    logic               push_ready;
    cmd_t               push_cmd;
    logic               cmd_valid;
    logic               cmd_pop;
    cmd_t               cmd;
    bk_status_t         bk_status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= SEED_ONE;
        end else if (cfg_wr_en) begin
            seed_reg <= cfg_seed_value;
        end
    end

    smsp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_reseed   (s_reseed),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    smsp_cmd_fifo u_cmd_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (cmd_valid),
        .pop_ready  (cmd_pop),
        .pop_cmd    (cmd)
    );

    smsp_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .seed           (seed_reg),
        .cmd_valid      (cmd_valid),
        .cmd_pop        (cmd_pop),
        .cmd            (cmd),
        .status         (bk_status),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_random_value (m_random_value)
    );

    // A word shown on the output always comes from a seeded table.
    `SMSP_ASSERT_IMPL(a_out_range, aclk, aresetn, m_valid, (m_random_value != '0) && (m_random_value != LCG_MOD), "Output word is outside the generator range.")
    // The sequencer takes a command only when the queue holds one.
    `SMSP_ASSERT_IMPL(a_pop_nonempty, aclk, aresetn, cmd_pop, cmd_valid, "Command popped from an empty queue.")
    // No result can appear while the table is being filled.
    `SMSP_ASSERT_NEXT(a_no_draw_in_fill, aclk, aresetn, bk_status.filling, !$rose(m_valid), "Result produced during table fill.")

endmodule
